[design/gcp_pkg.sv]
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types and constants for the graph credit propagation unit.
// ----------------------------------------------------------------------------
package gcp_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [1:0] CMD_RUN      = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_BAD_READ  = 2'd2;

    // field widths
    localparam int ID_W   = 12;
    localparam int DEG_W  = 16;
    localparam int REC_W  = 24;
    localparam int CRED_W = 32;
    localparam int CFG_W  = 5;

    localparam logic [DEG_W-1:0]  DEG_MAX  = '1;
    localparam logic [CRED_W-1:0] ONE_Q20  = CRED_W'(1) << 20;
    localparam logic [CRED_W-1:0] CRED_MAX = '1;

    // sequencer states
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_ADD_A,
        S_ADD_A2,
        S_ADD_B,
        S_ADD_B2,
        S_READ,
        S_READ2,
        S_RUN_RD,
        S_RUN_DIV0,
        S_RUN_DIV,
        S_RND_CLR,
        S_E_FETCH,
        S_E_EDGE,
        S_E_SRC,
        S_E_MUL,
        S_E_ACC,
        S_DONE
    } t_state;

endpackage

[design/gcp_recip_div.sv]
// ----------------------------------------------------------------------------
// gcp_recip_div
// Restoring divider for the UQ1.23 reciprocal of a node degree, rounded to
// nearest: (2^23 + d/2) / d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcp_recip_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gcp_pkg::DEG_W-1:0] i_degree,
    output logic                      o_busy,
    output logic [gcp_pkg::REC_W-1:0] o_quot
);
    import gcp_pkg::*;

    localparam int CNT_W = $clog2(REC_W);

    logic [REC_W-1:0] r_dq;
    logic [DEG_W:0]   r_rem;
    logic [DEG_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEG_W:0]   rem_sh;
    logic             ge;

    // trial subtraction of one step
    assign rem_sh = {r_rem[DEG_W-1:0], r_dq[REC_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // load on start, then shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= i_degree;
            r_dq   <= (REC_W'(1) << (REC_W - 1)) + REC_W'(i_degree >> 1);
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_dq  <= {r_dq[REC_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(REC_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dq;

endmodule

[design/graph_credit_propagation_unit.sv]
// ----------------------------------------------------------------------------
// graph_credit_propagation_unit
// Edge, degree, reciprocal and per-round credit stores in simple dual-port RAMs
// (one read and one write port each). A run first computes a reciprocal
// for every node of nonzero degree with the 24-step divider, then per round
// clears that round's bank and updates both ends of each edge. One item at a time.
// Reset sweeps all NODES entries zeroing degrees; input stays stalled.
// ----------------------------------------------------------------------------
module graph_credit_propagation_unit #(
    parameter int NODES       = 4096,
    parameter int EDGES       = 16384,
    parameter int ROUND_LIMIT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_node_a,
    input  logic [11:0] i_node_b,
    input  logic [4:0]  i_query_round,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_credit,
    output logic [15:0] o_degree,
    output logic [11:0] o_largest_node,
    output logic [14:0] o_edge_total,
    output logic [12:0] o_unique_nodes,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import gcp_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int EIW   = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECW   = $clog2(EDGES + 1);
    localparam int RW    = $clog2(ROUND_LIMIT + 1);
    localparam int UW    = $clog2(NODES + 1);
    localparam int CAW   = RW + NW;
    localparam int CDEPTH = (ROUND_LIMIT + 1) << NW;
    localparam int PW    = CRED_W + REC_W;

    // memories
    logic [DEG_W-1:0]  deg_mem  [NODES];
    logic [REC_W-1:0]  rec_mem  [NODES];
    logic [2*NW-1:0]   edge_mem [EDGES];
    logic [CRED_W-1:0] cred_mem [CDEPTH];

    logic [DEG_W-1:0]  deg_rdata;
    logic [REC_W-1:0]  rec_rdata;
    logic [2*NW-1:0]   edge_rdata;
    logic [CRED_W-1:0] cred_rdata;

    logic [NW-1:0]     deg_raddr, deg_waddr, rec_raddr;
    logic              deg_we, rec_we, edge_we, cred_we;
    logic [DEG_W-1:0]  deg_wdata;
    logic [REC_W-1:0]  rec_wdata;
    logic [EIW-1:0]    edge_raddr;
    logic [CAW-1:0]    cred_raddr, cred_waddr;
    logic [CRED_W-1:0] cred_wdata;

    // control state
    t_state            r_state, n_state;
    logic [ID_W-1:0]   r_a, r_b;
    logic [4:0]        r_q;
    logic [NW-1:0]     r_idx;
    logic [EIW-1:0]    r_eidx;
    logic [RW-1:0]     r_round, r_total, r_rounds_done;
    logic [ECW-1:0]    r_edge_count;
    logic [ID_W-1:0]   r_largest;
    logic [UW-1:0]     r_unique;
    logic              r_run_valid;
    logic [CFG_W-1:0]  r_rounds;
    logic              r_half;

    // edge datapath
    logic [NW-1:0]     r_ea, r_eb;
    logic [CRED_W-1:0] r_src, r_acc;
    logic [REC_W-1:0]  r_rec;
    logic [PW-1:0]     r_prod;

    // result registers
    logic [1:0]        r_res_status;
    logic [CRED_W-1:0] r_res_credit;
    logic [DEG_W-1:0]  r_res_degree;
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [CRED_W-1:0] r_o_credit;
    logic [DEG_W-1:0]  r_o_degree;
    logic [ID_W-1:0]   r_o_largest;
    logic [14:0]       r_o_edges;
    logic [12:0]       r_o_unique;

    // divider
    logic              div_start, div_busy;
    logic [REC_W-1:0]  div_quot;

    // derived values
    logic              accept, out_load;
    logic              add_drop, a_ok, b_ok, node_last, edge_last, round_last;
    logic              read_bad;
    logic [NW-1:0]     a_idx, b_idx, tgt;
    logic [RW-1:0]     total_c;
    logic [CRED_W:0]   term;
    logic [CRED_W+1:0] sum;
    logic [CRED_W-1:0] sat_sum;

    gcp_recip_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_degree (deg_rdata),
        .o_busy   (div_busy),
        .o_quot   (div_quot)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;

    assign a_ok      = 32'(r_a) < NODES;
    assign b_ok      = 32'(r_b) < NODES;
    assign a_idx     = NW'(r_a);
    assign b_idx     = NW'(r_b);
    assign add_drop  = (32'(i_node_a) >= NODES) || (32'(i_node_b) >= NODES)
                       || (32'(r_edge_count) >= EDGES);
    assign node_last = (r_idx == NW'(NODES - 1));
    assign edge_last = (ECW'(r_eidx) + ECW'(1)) == r_edge_count;
    assign round_last = (r_round == r_total);
    assign tgt       = r_half ? r_eb : r_ea;
    assign read_bad  = !r_run_valid || !a_ok || (32'(r_q) > 32'(r_rounds_done))
                       || (32'(r_q) > ROUND_LIMIT);

    // clamp the configured round count
    always_comb begin
        if (r_rounds == '0) begin
            total_c = RW'(1);
        end else if (32'(r_rounds) > ROUND_LIMIT) begin
            total_c = RW'(ROUND_LIMIT);
        end else begin
            total_c = RW'(r_rounds);
        end
    end

    // rounded term and saturating accumulate
    assign term    = (CRED_W+1)'((r_prod + PW'(1 << 22)) >> 23);
    assign sum     = (CRED_W+2)'(r_acc) + (CRED_W+2)'(term);
    assign sat_sum = (sum[CRED_W+1:CRED_W] != 2'b00) ? CRED_MAX : sum[CRED_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     if (node_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_ADD_EDGE: n_state = add_drop ? S_DONE : S_ADD_A;
                        CMD_RUN:      n_state = S_RUN_RD;
                        CMD_READ:     n_state = S_READ;
                        default:      n_state = S_CLEAR;
                    endcase
                end
            end
            S_CLEAR:    if (node_last) n_state = S_DONE;
            S_ADD_A:    n_state = S_ADD_A2;
            S_ADD_A2:   n_state = S_ADD_B;
            S_ADD_B:    n_state = S_ADD_B2;
            S_ADD_B2:   n_state = S_DONE;
            S_READ:     n_state = S_READ2;
            S_READ2:    n_state = S_DONE;
            S_RUN_RD:   n_state = S_RUN_DIV0;
            S_RUN_DIV0: begin
                if (deg_rdata != '0) begin
                    n_state = S_RUN_DIV;
                end else begin
                    n_state = node_last ? S_RND_CLR : S_RUN_RD;
                end
            end
            S_RUN_DIV: begin
                if (!div_busy) n_state = node_last ? S_RND_CLR : S_RUN_RD;
            end
            S_RND_CLR: begin
                if (node_last) begin
                    if (r_edge_count != '0) begin
                        n_state = S_E_FETCH;
                    end else begin
                        n_state = round_last ? S_DONE : S_RND_CLR;
                    end
                end
            end
            S_E_FETCH:  n_state = S_E_EDGE;
            S_E_EDGE:   n_state = S_E_SRC;
            S_E_SRC:    n_state = S_E_MUL;
            S_E_MUL:    n_state = S_E_ACC;
            S_E_ACC: begin
                if (!r_half) begin
                    n_state = S_E_SRC;
                end else if (!edge_last) begin
                    n_state = S_E_FETCH;
                end else begin
                    n_state = round_last ? S_DONE : S_RND_CLR;
                end
            end
            S_DONE:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_INIT;
        endcase
    end

    // memory controls
    always_comb begin
        deg_raddr  = a_idx;
        deg_we     = 1'b0;
        deg_waddr  = r_idx;
        deg_wdata  = '0;
        rec_raddr  = r_eb;
        rec_we     = 1'b0;
        rec_wdata  = '0;
        edge_we    = 1'b0;
        edge_raddr = r_eidx;
        cred_raddr = {RW'(r_q), a_idx};
        cred_we    = 1'b0;
        cred_waddr = {r_round, r_idx};
        cred_wdata = '0;
        div_start  = 1'b0;
        case (r_state)
            S_INIT, S_CLEAR: deg_we = 1'b1;
            S_ADD_A: edge_we = 1'b1;
            S_ADD_A2: begin
                deg_we    = 1'b1;
                deg_waddr = a_idx;
                deg_wdata = (deg_rdata == DEG_MAX) ? deg_rdata : deg_rdata + DEG_W'(1);
            end
            S_ADD_B: deg_raddr = b_idx;
            S_ADD_B2: begin
                deg_we    = 1'b1;
                deg_waddr = b_idx;
                deg_wdata = (deg_rdata == DEG_MAX) ? deg_rdata : deg_rdata + DEG_W'(1);
            end
            S_RUN_RD: begin
                deg_raddr  = r_idx;
                cred_we    = 1'b1;
                cred_waddr = {RW'(0), r_idx};
                cred_wdata = ONE_Q20;
            end
            S_RUN_DIV0: begin
                if (deg_rdata == '0) begin
                    rec_we = 1'b1;
                end else begin
                    div_start = 1'b1;
                end
            end
            S_RUN_DIV: begin
                rec_we    = !div_busy;
                rec_wdata = div_quot;
            end
            S_RND_CLR: cred_we = 1'b1;
            S_E_EDGE: begin
                cred_raddr = {r_round - RW'(1), edge_rdata[NW-1:0]};
                rec_raddr  = edge_rdata[NW-1:0];
            end
            S_E_SRC: cred_raddr = {r_round, tgt};
            S_E_ACC: begin
                cred_we    = 1'b1;
                cred_waddr = {r_round, tgt};
                cred_wdata = sat_sum;
                cred_raddr = {r_round - RW'(1), r_ea};
                rec_raddr  = r_ea;
            end
            default: ;
        endcase
    end

    // degree store
    always_ff @(posedge i_clk) begin
        if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
        deg_rdata <= deg_mem[deg_raddr];
    end

    // reciprocal store
    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[r_idx] <= rec_wdata;
        rec_rdata <= rec_mem[rec_raddr];
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (edge_we) edge_mem[EIW'(r_edge_count)] <= {a_idx, b_idx};
        edge_rdata <= edge_mem[edge_raddr];
    end

    // credit banks, one per round plus bank 0 for the initial credits
    always_ff @(posedge i_clk) begin
        if (cred_we) cred_mem[cred_waddr] <= cred_wdata;
        cred_rdata <= cred_mem[cred_raddr];
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_idx         <= '0;
            r_edge_count  <= '0;
            r_largest     <= '0;
            r_unique      <= '0;
            r_rounds_done <= '0;
            r_run_valid   <= 1'b0;
            r_rounds      <= CFG_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_rounds <= i_cfg_data;

            case (r_state)
                S_INIT, S_CLEAR: r_idx <= node_last ? '0 : r_idx + NW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_a          <= i_node_a;
                        r_b          <= i_node_b;
                        r_q          <= i_query_round;
                        r_idx        <= '0;
                        r_res_status <= ST_OK;
                        r_res_credit <= '0;
                        r_res_degree <= '0;
                        if (i_cmd == CMD_ADD_EDGE && add_drop) r_res_status <= ST_DROPPED;
                        if (i_cmd == CMD_RUN) begin
                            r_unique <= '0;
                            r_total  <= total_c;
                            r_round  <= RW'(1);
                        end
                        if (i_cmd == CMD_CLEAR) begin
                            r_edge_count  <= '0;
                            r_largest     <= '0;
                            r_unique      <= '0;
                            r_rounds_done <= '0;
                            r_run_valid   <= 1'b0;
                        end
                    end
                end
                S_ADD_A: begin
                    r_edge_count <= r_edge_count + ECW'(1);
                    r_run_valid  <= 1'b0;
                    if (r_a > r_largest && r_a >= r_b) r_largest <= r_a;
                    else if (r_b > r_largest) r_largest <= r_b;
                end
                S_READ2: begin
                    r_res_degree <= a_ok ? deg_rdata : '0;
                    r_res_status <= read_bad ? ST_BAD_READ : ST_OK;
                    r_res_credit <= read_bad ? '0 : cred_rdata;
                end
                S_RUN_DIV0: begin
                    if (deg_rdata != '0) begin
                        r_unique <= r_unique + UW'(1);
                    end else begin
                        r_idx <= node_last ? '0 : r_idx + NW'(1);
                    end
                end
                S_RUN_DIV: if (!div_busy) r_idx <= node_last ? '0 : r_idx + NW'(1);
                S_RND_CLR: begin
                    r_idx  <= node_last ? '0 : r_idx + NW'(1);
                    r_eidx <= '0;
                    if (node_last && r_edge_count == '0) begin
                        if (round_last) begin
                            r_rounds_done <= r_total;
                            r_run_valid   <= 1'b1;
                        end else begin
                            r_round <= r_round + RW'(1);
                        end
                    end
                end
                S_E_EDGE: begin
                    r_ea   <= edge_rdata[2*NW-1:NW];
                    r_eb   <= edge_rdata[NW-1:0];
                    r_half <= 1'b0;
                end
                S_E_SRC: begin
                    r_src <= cred_rdata;
                    r_rec <= rec_rdata;
                end
                S_E_MUL: begin
                    r_prod <= PW'(r_src) * PW'(r_rec);
                    r_acc  <= cred_rdata;
                end
                S_E_ACC: begin
                    if (!r_half) begin
                        r_half <= 1'b1;
                    end else if (!edge_last) begin
                        r_eidx <= r_eidx + EIW'(1);
                    end else if (round_last) begin
                        r_rounds_done <= r_total;
                        r_run_valid   <= 1'b1;
                    end else begin
                        r_round <= r_round + RW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // output register: hold the result until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status  <= r_res_status;
            r_o_credit  <= r_res_credit;
            r_o_degree  <= r_res_degree;
            r_o_largest <= r_largest;
            r_o_edges   <= 15'(r_edge_count);
            r_o_unique  <= 13'(r_unique);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_credit       = r_o_credit;
    assign o_degree       = r_o_degree;
    assign o_largest_node = r_o_largest;
    assign o_edge_total   = r_o_edges;
    assign o_unique_nodes = r_o_unique;

endmodule
